// File: hdl/ntlru_pkg.sv
// ----------------------------------------------------------------------------
// ntlru_pkg
// Shared types and constants for the node table with LRU-by-advert replacement.
// ----------------------------------------------------------------------------
package ntlru_pkg;

  localparam int SLOTS_DEF  = 64;
  localparam int OPCODE_W   = 3;
  localparam int DATA_W     = 32;
  localparam int SLOT_IDX_W = 8;
  localparam int RES_SLOT_W = 6;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DATA_W-1:0]  WALL_VALID_FROM = 32'd1700000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 7'd127;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_PUT     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DUE     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MARK    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SWEEP   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_VISIBLE = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_CNT_DUE = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_CNT_VIS = 3'd7;

  // put outcome
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVICT  = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word, clear accumulators
    logic rd_en;      // issue a table read
    logic rd_single;  // read at the addressed slot instead of the scan index
    logic commit;     // apply table writes, load output register
  } ntlru_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_scan;    // current opcode walks the whole table
    logic out_free;   // output register can take a word this cycle
  } ntlru_stat_t;

endpackage

// File: hdl/ntlru_ctrl.sv
// ----------------------------------------------------------------------------
// ntlru_ctrl
// Sequencer: accept, issue table reads (one slot or a full scan), commit.
// ----------------------------------------------------------------------------
module ntlru_ctrl #(
  parameter int SLOTS = ntlru_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ntlru_pkg::ntlru_stat_t     st,
  output ntlru_pkg::ntlru_cmd_t      cmd,
  output logic [$clog2(SLOTS)-1:0]   rd_addr
);
  import ntlru_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_FIN   = 4'b1000
  } ntlru_state_t;

  ntlru_state_t state_r, state_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign rd_addr  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (!st.is_scan) begin
          cmd.rd_single = 1'b1;
          state_nxt     = S_WAIT;
        end else if (cnt_r == LAST) begin
          state_nxt = S_WAIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_WAIT: begin
        // last read is evaluated this cycle
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hdl/ntlru_dp.sv
// ----------------------------------------------------------------------------
// ntlru_dp
// Table memories, occupancy bits, per-slot evaluation, scan accumulators,
// config registers and the output register.
// ----------------------------------------------------------------------------
module ntlru_dp #(
  parameter int SLOTS = ntlru_pkg::SLOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ntlru_pkg::ntlru_cmd_t                  cmd,
  input  logic [$clog2(SLOTS)-1:0]               rd_addr,
  output ntlru_pkg::ntlru_stat_t                 st,
  input  logic [ntlru_pkg::OPCODE_W-1:0]         in_opcode,
  input  logic [ntlru_pkg::DATA_W-1:0]           in_node_key,
  input  logic [ntlru_pkg::DATA_W-1:0]           in_advert_time,
  input  logic [ntlru_pkg::SLOT_IDX_W-1:0]       in_slot_index,
  input  logic [ntlru_pkg::DATA_W-1:0]           in_now_millis,
  input  logic [ntlru_pkg::DATA_W-1:0]           in_wall_secs,
  input  logic                                   cfg_wr,
  input  logic [ntlru_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ntlru_pkg::DATA_W-1:0]           cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ntlru_pkg::RES_SLOT_W-1:0]       out_result_slot,
  output logic [ntlru_pkg::MODE_W-1:0]           out_put_mode,
  output logic                                   out_answer_flag,
  output logic [ntlru_pkg::COUNT_W-1:0]          out_answer_count,
  output logic                                   out_error_flag
);
  import ntlru_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam logic [SLOT_IDX_W:0] SLOTS_LIM = (SLOT_IDX_W + 1)'(SLOTS);

  // config
  logic [DATA_W-1:0] refresh_r, stale_r, visible_r;

  // captured input word
  logic [OPCODE_W-1:0]   op_r;
  logic [DATA_W-1:0]     key_r, adv_r, now_ms_r, wall_secs_r;
  logic [SLOT_IDX_W-1:0] slot_r;

  // table
  logic [DATA_W-1:0] key_mem  [SLOTS];
  logic [DATA_W-1:0] adv_mem  [SLOTS];
  logic [DATA_W-1:0] post_mem [SLOTS];
  logic [DATA_W-1:0] key_q, adv_q, post_q;
  logic [SLOTS-1:0]  valid_r;

  // read pipeline
  logic          rd_v_r;
  logic [SW-1:0] idx_r;
  logic [SW-1:0] rd_a;

  // accumulators
  logic              found_v_r, empty_v_r, old_v_r;
  logic [SW-1:0]     found_idx_r, empty_idx_r, old_idx_r;
  logic [DATA_W-1:0] old_adv_r;
  logic [COUNT_W-1:0] cnt_r;
  logic              flag_r, occ_r;

  logic out_valid_r;

  // ---------------- per-slot evaluation ----------------
  logic              occ, due, vis, stale, hit, wall_ok;
  logic [DATA_W-1:0] age_ms, age_wall;
  logic [DATA_W:0]   stale_lim;

  assign occ       = valid_r[idx_r];
  assign age_ms    = now_ms_r - post_q;
  assign age_wall  = wall_secs_r - adv_q;
  assign wall_ok   = (wall_secs_r >= WALL_VALID_FROM);
  assign stale_lim = {1'b0, adv_q} + {1'b0, stale_r};
  assign due       = occ && ((post_q == '0) || (age_ms >= refresh_r));
  assign vis       = occ && (!wall_ok || ((wall_secs_r >= adv_q) && (age_wall <= visible_r)));
  assign stale     = occ && wall_ok && ({1'b0, wall_secs_r} > stale_lim);

  always_comb begin
    case (op_r)
      OP_SWEEP:   hit = stale;
      OP_CNT_DUE: hit = due;
      OP_CNT_VIS: hit = vis;
      default:    hit = 1'b0;
    endcase
  end

  // ---------------- opcode decode ----------------
  logic scan_op, slot_op, count_op, err;
  always_comb begin
    case (op_r) inside
      OP_PUT, OP_SWEEP, OP_CNT_DUE, OP_CNT_VIS: scan_op = 1'b1;
      default:                                  scan_op = 1'b0;
    endcase
    case (op_r) inside
      OP_DUE, OP_MARK, OP_REMOVE, OP_VISIBLE: slot_op = 1'b1;
      default:                                slot_op = 1'b0;
    endcase
    case (op_r) inside
      OP_SWEEP, OP_CNT_DUE, OP_CNT_VIS: count_op = 1'b1;
      default:                          count_op = 1'b0;
    endcase
  end

  assign err       = slot_op && ({1'b0, slot_r} >= SLOTS_LIM);
  assign out_valid = out_valid_r;
  assign st        = '{is_scan: scan_op, out_free: (!out_valid_r || !out_stall)};

  // ---------------- commit ----------------
  logic [SW-1:0]     slot_a, put_tgt, post_wa;
  logic [MODE_W-1:0] put_mode;
  logic [DATA_W-1:0] adv_st, post_val, post_wd;
  logic              wr_put, wr_mark, post_we;

  assign slot_a   = slot_r[SW-1:0];
  assign put_tgt  = found_v_r ? found_idx_r : (empty_v_r ? empty_idx_r : old_idx_r);
  assign put_mode = found_v_r ? MODE_UPDATE : (empty_v_r ? MODE_FILL : MODE_EVICT);
  assign adv_st   = (adv_r == '0) ? DATA_W'(1) : adv_r;
  assign post_val = (now_ms_r == '0) ? DATA_W'(1) : now_ms_r;
  assign wr_put   = cmd.commit && (op_r == OP_PUT);
  assign wr_mark  = cmd.commit && (op_r == OP_MARK) && !err && occ_r;
  assign post_we  = (wr_put && !found_v_r) || wr_mark;   // update keeps posted tick
  assign post_wa  = wr_put ? put_tgt : slot_a;
  assign post_wd  = wr_put ? '0 : post_val;
  assign rd_a     = cmd.rd_single ? slot_a : rd_addr;

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (wr_put) begin
      key_mem[put_tgt] <= key_r;
      adv_mem[put_tgt] <= adv_st;
    end
    if (post_we) begin
      post_mem[post_wa] <= post_wd;
    end
    if (cmd.rd_en) begin
      key_q  <= key_mem[rd_a];
      adv_q  <= adv_mem[rd_a];
      post_q <= post_mem[rd_a];
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      refresh_r   <= '0;
      stale_r     <= '0;
      visible_r   <= '0;
    end else begin
      rd_v_r <= cmd.rd_en;
      if (rd_v_r && (op_r == OP_SWEEP) && stale) begin
        valid_r[idx_r] <= 1'b0;
      end
      if (wr_put) begin
        valid_r[put_tgt] <= 1'b1;
      end
      if (cmd.commit && (op_r == OP_REMOVE) && !err) begin
        valid_r[slot_a] <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_REFRESH: refresh_r <= cfg_data;
          CFG_STALE:   stale_r   <= cfg_data;
          CFG_VISIBLE: visible_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------- input capture and accumulators ----------------
  always_ff @(posedge clk) begin
    idx_r <= rd_a;
    if (cmd.load) begin
      op_r        <= in_opcode;
      key_r       <= in_node_key;
      adv_r       <= in_advert_time;
      slot_r      <= in_slot_index;
      now_ms_r    <= in_now_millis;
      wall_secs_r <= in_wall_secs;
      found_v_r   <= 1'b0;
      empty_v_r   <= 1'b0;
      old_v_r     <= 1'b0;
      cnt_r       <= '0;
    end else if (rd_v_r) begin
      if (op_r == OP_PUT) begin
        if (!occ) begin
          if (!empty_v_r) begin
            empty_v_r   <= 1'b1;
            empty_idx_r <= idx_r;
          end
        end else begin
          if (!found_v_r && (key_q == key_r)) begin
            found_v_r   <= 1'b1;
            found_idx_r <= idx_r;
          end
          if (!old_v_r || (adv_q < old_adv_r)) begin
            old_v_r   <= 1'b1;
            old_idx_r <= idx_r;
            old_adv_r <= adv_q;
          end
        end
      end
      if (hit && (cnt_r != COUNT_MAX)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      occ_r <= occ;
      case (op_r)
        OP_DUE:    flag_r <= due;
        OP_REMOVE: flag_r <= occ;
        default:   flag_r <= vis;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_result_slot  <= (op_r == OP_PUT) ? RES_SLOT_W'(put_tgt) : '0;
      out_put_mode     <= (op_r == OP_PUT) ? put_mode : MODE_UPDATE;
      out_answer_flag  <= (!err && (op_r == OP_DUE || op_r == OP_REMOVE ||
                           op_r == OP_VISIBLE)) ? flag_r : 1'b0;
      out_answer_count <= count_op ? cnt_r : '0;
      out_error_flag   <= err;
    end
  end

endmodule

// File: hdl/node_table_lru_timestamp_unit.sv
// ----------------------------------------------------------------------------
// node_table_lru_timestamp_unit
// Node table with least-recently-advertised replacement, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per command. The word is
//   taken at an edge with in_valid high and in_stall low. in_stall is high
//   while a command is in progress; only one command is worked at a time.
//   Result channel (out_valid / out_stall): exactly one result word per
//   command, held in an output register until taken. A new command can be
//   accepted while the previous result still waits.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   only while the unit is idle. Index 0 refresh_ms, 1 stale_secs,
//   2 visible_secs; other indexes are ignored.
// Sequence:
//   Every command runs accept + read issue + evaluation of the last read + commit.
//   Put, sweep and the count commands scan the table one slot per cycle
//   through the registered memory read port; slot commands read only the
//   addressed slot. If out_stall holds a previous result, commit waits in
//   place.
// Reset:
//   rst_n (sync, active low) empties the table by clearing the per-slot
//   occupancy bits and zeroes the config registers; no clearing pass.
// ----------------------------------------------------------------------------
module node_table_lru_timestamp_unit #(
  parameter int SLOTS = ntlru_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ntlru_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [ntlru_pkg::DATA_W-1:0]       in_node_key,
  input  logic [ntlru_pkg::DATA_W-1:0]       in_advert_time,
  input  logic [ntlru_pkg::SLOT_IDX_W-1:0]   in_slot_index,
  input  logic [ntlru_pkg::DATA_W-1:0]       in_now_millis,
  input  logic [ntlru_pkg::DATA_W-1:0]       in_wall_secs,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ntlru_pkg::RES_SLOT_W-1:0]   out_result_slot,
  output logic [ntlru_pkg::MODE_W-1:0]       out_put_mode,
  output logic                               out_answer_flag,
  output logic [ntlru_pkg::COUNT_W-1:0]      out_answer_count,
  output logic                               out_error_flag,
  // config writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ntlru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ntlru_pkg::DATA_W-1:0]       cfg_data
);
  import ntlru_pkg::*;

  ntlru_cmd_t                 cmd;
  ntlru_stat_t                st;
  logic [$clog2(SLOTS)-1:0]   rd_addr;

  assign cfg_ready = 1'b1;

  // sequencer: owns the handshake on the input side and the scan index
  ntlru_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // table, evaluation, accumulators, output register
  ntlru_dp #(.SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .st               (st),
    .in_opcode        (in_opcode),
    .in_node_key      (in_node_key),
    .in_advert_time   (in_advert_time),
    .in_slot_index    (in_slot_index),
    .in_now_millis    (in_now_millis),
    .in_wall_secs     (in_wall_secs),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_slot  (out_result_slot),
    .out_put_mode     (out_put_mode),
    .out_answer_flag  (out_answer_flag),
    .out_answer_count (out_answer_count),
    .out_error_flag   (out_error_flag)
  );

endmodule

// File: hdl/ntlru_chk.sv
// ----------------------------------------------------------------------------
// ntlru_chk
// Port-level checks for the node table, bound to the top level.
// ----------------------------------------------------------------------------
module ntlru_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [ntlru_pkg::RES_SLOT_W-1:0]   out_result_slot,
  input logic [ntlru_pkg::MODE_W-1:0]       out_put_mode,
  input logic                               out_answer_flag,
  input logic [ntlru_pkg::COUNT_W-1:0]      out_answer_count,
  input logic                               out_error_flag
);
  import ntlru_pkg::*;

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_slot) &&
      $stable(out_put_mode) && $stable(out_answer_flag) &&
      $stable(out_answer_count) && $stable(out_error_flag))
    else $error("result word changed while stalled");

  // one command at a time: busy right after accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again without processing");

  // an error result carries no answer
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> !out_answer_flag && out_answer_count == '0 &&
      out_put_mode == MODE_UPDATE && out_result_slot == '0)
    else $error("error result carries answer fields");

  // put_mode is never the unused code
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_put_mode == MODE_UPDATE) || (out_put_mode == MODE_FILL) ||
      (out_put_mode == MODE_EVICT))
    else $error("illegal put_mode");

endmodule

bind node_table_lru_timestamp_unit ntlru_chk u_ntlru_chk (.*);
